// ===== hdl/c_escape_decoder_core_defines.svh =====
// Assertion macros used by the escape decoder checker.
`ifndef C_ESCAPE_DECODER_CORE_DEFINES_SVH
`define C_ESCAPE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("escape decoder check failed");

// Next-cycle implication, disabled while reset is low.
`define CED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`endif

// ===== hdl/ced_pkg.sv =====
// Package with status codes, byte constants and the escape letter map.
package ced_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned OUT_COUNT_BITS = 16;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_FAILED  = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_map_t;

  // Map the letter after a backslash onto the byte it stands for.
  function automatic esc_map_t map_escape(input logic [7:0] c, input logic char_mode);
    esc_map_t r;
    r.ok  = 1'b1;
    r.val = 8'h00;
    unique case (c)
      CH_BSLASH: r.val = CH_BSLASH;
      8'h61:     r.val = 8'h07;
      8'h62:     r.val = 8'h08;
      8'h65:     r.val = 8'h1b;
      8'h66:     r.val = 8'h0c;
      8'h6e:     r.val = 8'h0a;
      8'h72:     r.val = 8'h0d;
      8'h74:     r.val = 8'h09;
      CH_SQUOTE: begin
        r.ok  = char_mode;
        r.val = CH_SQUOTE;
      end
      CH_DQUOTE: begin
        r.ok  = ~char_mode;
        r.val = CH_DQUOTE;
      end
      default:   r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ced_if.sv =====
// Stream interfaces for escaped input bytes and decoded result words.
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       starts_string;
  logic       ends_string;

  modport source (output valid, in_byte, starts_string, ends_string, input ready);
  modport sink   (input valid, in_byte, starts_string, ends_string, output ready);
endinterface

interface ced_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic [1:0]  status;
  logic [15:0] bytes_consumed;

  modport source (output valid, out_byte, out_valid, status, bytes_consumed, input ready);
  modport sink   (input valid, out_byte, out_valid, status, bytes_consumed, output ready);
endinterface

// ===== hdl/c_escape_decoder_core.sv =====
// Streaming decoder for escaped C string and character literals.
//
// Usage:
//   in_i  carries one escaped byte per word with start and end marks.
//   out_o carries one result word per input word: the decoded byte and its
//         flag, a status (in progress, finished, failed, ignored) and the
//         count of bytes consumed, held at its maximum on overflow.
//   cfg_we_i/cfg_wdata_i write the character-mode bit; write it only while
//   no word is in flight.
// Timing: the result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle. The single result register sets this;
//   a new word is taken whenever that register is empty or being drained.
// Reset: clears escape mode, the failure flag, the count, the mode bit and
//   the result register's valid flag.
// Stall: while out_o.ready is low and a result waits, in_i.ready drops and
//   the decoder state holds; nothing is lost or repeated.
module c_escape_decoder_core #(
  parameter int unsigned COUNT_BITS = ced_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ced_in_if.sink    in_i,
  ced_out_if.source out_o
);

  localparam int unsigned OCB = ced_pkg::OUT_COUNT_BITS;

  // Mode register
  logic char_mode_q;

  // Decoder state
  logic                  esc_q, esc_d;
  logic                  fail_q, fail_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  // Result register
  logic             res_vld_q;
  logic [7:0]       res_byte_q, res_byte_d;
  logic             res_bv_q, res_bv_d;
  ced_pkg::status_e res_st_q, res_st_d;
  logic [OCB-1:0]   res_cnt_q, res_cnt_d;

  logic                  accept;
  logic                  esc_base, fail_base;
  logic [COUNT_BITS-1:0] cnt_base, cnt_inc;
  ced_pkg::esc_map_t     emap;

  // Take a word when the result register is empty or being drained
  assign in_i.ready = ~res_vld_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  // A start mark clears the state before this byte is decoded
  assign esc_base  = in_i.starts_string ? 1'b0 : esc_q;
  assign fail_base = in_i.starts_string ? 1'b0 : fail_q;
  assign cnt_base  = in_i.starts_string ? '0 : cnt_q;
  // Hold the count at all ones once reached
  assign cnt_inc   = (&cnt_base) ? cnt_base : cnt_base + COUNT_BITS'(1);

  assign emap = ced_pkg::map_escape(in_i.in_byte, char_mode_q);

  always_comb begin
    esc_d      = esc_base;
    fail_d     = fail_base;
    cnt_d      = cnt_base;
    res_byte_d = 8'h00;
    res_bv_d   = 1'b0;
    res_st_d   = in_i.ends_string ? ced_pkg::ST_DONE : ced_pkg::ST_BUSY;
    if (fail_base) begin
      // Drop everything until the next start mark
      res_st_d = ced_pkg::ST_IGNORED;
    end else if (!esc_base) begin
      if (in_i.in_byte == ced_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end else begin
        res_byte_d = in_i.in_byte;
        res_bv_d   = 1'b1;
      end
      cnt_d = cnt_inc;
    end else if (emap.ok) begin
      res_byte_d = emap.val;
      res_bv_d   = 1'b1;
      esc_d      = 1'b0;
      cnt_d      = cnt_inc;
    end else begin
      // Illegal escape: fail the literal, count does not advance
      esc_d    = 1'b0;
      fail_d   = 1'b1;
      res_st_d = ced_pkg::ST_FAILED;
    end
    // An end mark always leaves escape mode, so a lone trailing backslash ends cleanly
    if (in_i.ends_string) begin
      esc_d = 1'b0;
    end
  end

  // Present the count clipped or zero-extended to the output field width
  generate
    if (COUNT_BITS > OCB) begin : g_clip
      assign res_cnt_d = (|cnt_d[COUNT_BITS-1:OCB]) ? {OCB{1'b1}} : cnt_d[OCB-1:0];
    end else if (COUNT_BITS == OCB) begin : g_same
      assign res_cnt_d = cnt_d;
    end else begin : g_ext
      assign res_cnt_d = {{(OCB - COUNT_BITS){1'b0}}, cnt_d};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_mode_q <= 1'b0;
      esc_q       <= 1'b0;
      fail_q      <= 1'b0;
      cnt_q       <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        char_mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        esc_q     <= esc_d;
        fail_q    <= fail_d;
        cnt_q     <= cnt_d;
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload of the result register needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_byte_q <= res_byte_d;
      res_bv_q   <= res_bv_d;
      res_st_q   <= res_st_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  assign out_o.valid          = res_vld_q;
  assign out_o.out_byte       = res_byte_q;
  assign out_o.out_valid      = res_bv_q;
  assign out_o.status         = res_st_q;
  assign out_o.bytes_consumed = res_cnt_q;

endmodule

// ===== hdl/ced_checker.sv =====
// Port-level checker for the escape decoder and its bind statement.
`include "c_escape_decoder_core_defines.svh"

module ced_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        out_bv_i,
  input logic [1:0]  status_i
);

  // A result word stays offered until taken
  `CED_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Every taken input word yields a result word in the next cycle
  `CED_ASSERT_NXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)

  // Failed and ignored words carry no decoded byte
  `CED_ASSERT_IMP(a_no_byte_on_fail, clk_i, rst_ni,
    out_valid_i && (status_i == ced_pkg::ST_FAILED || status_i == ced_pkg::ST_IGNORED),
    !out_bv_i && out_byte_i == 8'h00)

  // Input is never refused while the result register is empty
  `CED_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind c_escape_decoder_core ced_checker u_ced_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_bv_i    (out_o.out_valid),
  .status_i    (out_o.status)
);
